// File: src/md5de_pkg.sv
// Shared types, round constants and helper functions of the MD5 digest engine.
package md5de_pkg;

    // Control states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_CINIT = 6'b000100,
        S_CRUN  = 6'b001000,
        S_CADD  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // Padding sequence position
    typedef enum logic [1:0] {
        PH_MARK  = 2'd0,
        PH_ZERO  = 2'd1,
        PH_LENHI = 2'd2
    } pad_phase_t;

    // Block memory write port
    typedef struct packed {
        logic        we;
        logic [3:0]  addr;
        logic [31:0] data;
    } mem_wr_t;

    localparam logic [31:0] INIT_CHAIN [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };

    localparam logic [31:0] PAD_MARK   = 32'h0000_0080;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] SHIFT_TABLE [4][4] = '{
        '{5'd7, 5'd12, 5'd17, 5'd22},
        '{5'd5, 5'd9,  5'd14, 5'd20},
        '{5'd4, 5'd11, 5'd16, 5'd23},
        '{5'd6, 5'd10, 5'd15, 5'd21}
    };

    localparam logic [3:0] IDX_MUL [4] = '{4'd1, 4'd5, 4'd3, 4'd7};
    localparam logic [3:0] IDX_ADD [4] = '{4'd0, 4'd1, 4'd5, 4'd0};

    // Message word index used by a given round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [1:0] stg;
        logic [3:0] j;
        stg = rnd[5:4];
        j   = rnd[3:0];
        return 4'(IDX_MUL[stg] * j + IDX_ADD[stg]);
    endfunction

    // Final partial word: keep the low n bytes, append the marker byte
    function automatic logic [31:0] pad_word(input logic [31:0] msg, input logic [2:0] n);
        logic [31:0] w;
        unique case (n[1:0])
            2'd0: w = PAD_MARK;
            2'd1: w = {16'h0000, PAD_MARK[7:0], msg[7:0]};
            2'd2: w = {8'h00, PAD_MARK[7:0], msg[15:0]};
            2'd3: w = {PAD_MARK[7:0], msg[23:0]};
        endcase
        return w;
    endfunction

endpackage

// File: src/md5de_word_mem.sv
// 16 x 32 block word memory, one write and one registered read port.
module md5de_word_mem (
    input  logic                clk,
    input  md5de_pkg::mem_wr_t  wr,
    input  logic [3:0]          raddr,
    output logic [31:0]         rdata
);
    import md5de_pkg::*;

    logic [31:0] mem [16];
    logic [31:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/md5de_round.sv
// One MD5 round step on the A..D working registers.
module md5de_round (
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    input  logic [31:0] k,
    input  logic [1:0]  stage,
    input  logic [4:0]  shift,
    output logic [31:0] a_new,
    output logic [31:0] b_new,
    output logic [31:0] c_new,
    output logic [31:0] d_new
);
    import md5de_pkg::*;

    logic [31:0] mix;
    logic [31:0] sum;
    logic [63:0] dbl;

    // Stage-dependent boolean function
    always_comb
    begin
        unique case (stage)
            2'd0: mix = (b & c) | (~b & d);
            2'd1: mix = (d & b) | (~d & c);
            2'd2: mix = b ^ c ^ d;
            2'd3: mix = c ^ (b | ~d);
        endcase
    end

    assign sum = a + mix + k + m;
    assign dbl = {sum, sum} << shift;

    // Rotate the registers
    assign a_new = d;
    assign b_new = b + dbl[63:32];
    assign c_new = b;
    assign d_new = c;

endmodule

// File: src/md5_digest_engine_top.sv
// MD5 digest engine top level: word intake, padding, compression control, digest output.
//
// Message words come in on s_* as little-endian 32-bit words; s_tlast marks the final
// word, whose valid bytes are given by byte_count. Each word is one transaction and is
// written to a 16-entry block memory. When a block is full the engine runs compression
// (one load step, 64 rounds through a single round unit that reads one memory word per
// cycle, one chaining add). The final word starts padding, written one word per cycle,
// with one or two extra compressions. The four digest words h0..h3 then move to an
// output buffer and leave on m_* (m_tlast on h3); the next message may start while the
// digest is still being drained.
module md5_digest_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] msg_word, [34:32] byte_count, [39:35] zero
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast    // digest_last
);
    import md5de_pkg::*;

    state_t      state_reg, state_next;
    pad_phase_t  phase_reg;
    logic [3:0]  fill_reg;
    logic [63:0] bitlen_reg;
    logic [5:0]  rnd_reg;
    logic        pad_reg;
    logic        fin_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] work_reg [4];
    logic [31:0] obuf_reg [4];
    logic [1:0]  oidx_reg;
    logic        obusy_reg;

    logic        in_acc;
    logic        out_acc;
    logic [31:0] msg_word;
    logic [2:0]  byte_n;
    logic [31:0] first_word;
    logic [31:0] pad_data;
    mem_wr_t     wr;
    logic [3:0]  raddr;
    logic [31:0] rdata;
    logic [31:0] rnd_out [4];

    assign in_acc   = s_tvalid & s_tready;
    assign out_acc  = m_tvalid & m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign msg_word = s_tdata[31:0];
    assign byte_n   = (s_tdata[34:32] > FULL_BYTES) ? FULL_BYTES : s_tdata[34:32];

    // Word written on an input transaction
    assign first_word = (!s_tlast || byte_n == FULL_BYTES) ? msg_word
                                                           : pad_word(msg_word, byte_n);

    // Padding word for the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_MARK:  pad_data = PAD_MARK;
            PH_ZERO:  pad_data = (fill_reg == 4'd14) ? bitlen_reg[31:0] : '0;
            PH_LENHI: pad_data = bitlen_reg[63:32];
            default:  pad_data = '0;
        endcase
    end

    // Block memory write port
    always_comb
    begin
        wr.we   = in_acc | (state_reg == S_PAD);
        wr.addr = fill_reg;
        wr.data = (state_reg == S_PAD) ? pad_data : first_word;
    end

    // Read address runs one round ahead of the round unit
    always_comb
    begin
        if (state_reg == S_CINIT)
        begin
            raddr = msg_index(6'd0);
        end
        else
        begin
            raddr = msg_index(rnd_reg + 6'd1);
        end
    end

    md5de_word_mem u_mem (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    md5de_round u_round (
        .a     (work_reg[0]),
        .b     (work_reg[1]),
        .c     (work_reg[2]),
        .d     (work_reg[3]),
        .m     (rdata),
        .k     (K_TABLE[rnd_reg]),
        .stage (rnd_reg[5:4]),
        .shift (SHIFT_TABLE[rnd_reg[5:4]][rnd_reg[1:0]]),
        .a_new (rnd_out[0]),
        .b_new (rnd_out[1]),
        .c_new (rnd_out[2]),
        .d_new (rnd_out[3])
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (fill_reg == 4'd15)
                    begin
                        state_next = S_CINIT;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                if (fill_reg == 4'd15)
                begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT: state_next = S_CRUN;
            S_CRUN:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = S_CADD;
                end
            end
            S_CADD:
            begin
                priority if (fin_reg)
                begin
                    state_next = S_DONE;
                end
                else if (pad_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (!obusy_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_MARK;
            fill_reg   <= '0;
            bitlen_reg <= '0;
            rnd_reg    <= '0;
            pad_reg    <= 1'b0;
            fin_reg    <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= INIT_CHAIN[i];
                work_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (wr.we)
            begin
                fill_reg <= fill_reg + 4'd1;
            end

            // Input transaction: length and padding start
            if (in_acc)
            begin
                bitlen_reg <= bitlen_reg + (s_tlast ? 64'(byte_n) << 3 : 64'd32);
                if (s_tlast)
                begin
                    pad_reg   <= 1'b1;
                    phase_reg <= (byte_n == FULL_BYTES) ? PH_MARK : PH_ZERO;
                end
            end

            // Padding sequence
            if (state_reg == S_PAD)
            begin
                unique case (phase_reg)
                    PH_MARK: phase_reg <= PH_ZERO;
                    PH_ZERO:
                    begin
                        if (fill_reg == 4'd14)
                        begin
                            phase_reg <= PH_LENHI;
                        end
                    end
                    PH_LENHI: fin_reg <= 1'b1;
                    default:  phase_reg <= PH_MARK;
                endcase
            end

            // Compression
            if (state_reg == S_CINIT)
            begin
                rnd_reg <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    work_reg[i] <= chain_reg[i];
                end
            end
            if (state_reg == S_CRUN)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                for (int i = 0; i < 4; i++)
                begin
                    work_reg[i] <= rnd_out[i];
                end
            end
            if (state_reg == S_CADD)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end

            // Digest handed to the output buffer, engine back to initial values
            if (state_reg == S_DONE && !obusy_reg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_reg[i] <= INIT_CHAIN[i];
                end
                bitlen_reg <= '0;
                pad_reg    <= 1'b0;
                fin_reg    <= 1'b0;
            end
        end
    end

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obusy_reg <= 1'b0;
            oidx_reg  <= '0;
        end
        else
        begin
            if (state_reg == S_DONE && !obusy_reg)
            begin
                obusy_reg <= 1'b1;
                oidx_reg  <= '0;
            end
            else if (out_acc)
            begin
                oidx_reg <= oidx_reg + 2'd1;
                if (oidx_reg == 2'd3)
                begin
                    obusy_reg <= 1'b0;
                end
            end
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && !obusy_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                obuf_reg[i] <= chain_reg[i];
            end
        end
    end

    assign m_tvalid = obusy_reg;
    assign m_tdata  = obuf_reg[oidx_reg];
    assign m_tlast  = (oidx_reg == 2'd3);

endmodule

// File: src/md5de_checker.sv
// Port-level checks of the MD5 digest engine, bound to the top level.
module md5de_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    // A stalled digest transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("digest transaction changed while stalled");

    // Padding or a block compression always follows the final word, so intake stops
    a_pad_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted right after final word");

    // The buffer is empty after the last digest word is taken
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("output still valid after digest end");

    // A digest starts with h0, never with the last word
    a_out_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !m_tlast)
        else $error("digest started on its last word");

endmodule

bind md5_digest_engine_top md5de_checker u_md5de_checker (.*);
